// ===== rtl/core/utf8d_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 code point decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int ByteW  = 8;
  localparam int CpW    = 21;
  localparam int RunMax = 4;            // longest run: three held bytes plus one
  localparam int LenW   = 3;            // holds 0..RunMax
  localparam int PosW   = 2;            // indexes a run position
  localparam int QDepth = 2;            // entries in each internal queue

  localparam logic [CpW-1:0]   REPLACEMENT = 21'h00FFFD;
  localparam logic [ByteW-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [2:0]       LEAD2_TAG   = 3'h6;
  localparam logic [3:0]       LEAD3_TAG   = 4'hE;
  localparam logic [4:0]       LEAD4_TAG   = 5'h1E;

  // Sequence lengths a lead byte announces.
  localparam logic [LenW-1:0] LEN_BAD  = 3'd0;
  localparam logic [LenW-1:0] LEN_ONE  = 3'd1;
  localparam logic [LenW-1:0] LEN_TWO  = 3'd2;
  localparam logic [LenW-1:0] LEN_THR  = 3'd3;
  localparam logic [LenW-1:0] LEN_FOUR = 3'd4;

  // One run of bytes to decode, handed from the front to the back.
  typedef struct packed {
    logic [RunMax-1:0][ByteW-1:0] bytes;
    logic [LenW-1:0]              len;    // 1..RunMax
    logic                         done;   // run closes the string
  } job_t;

  typedef struct packed {
    logic           valid;
    job_t           job;
  } job_push_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           run_last;
    logic           string_done;
  } result_t;

  function automatic logic [LenW-1:0] lead_len(input logic [ByteW-1:0] c);
    logic [LenW-1:0] l;
    if (c < ASCII_LIMIT)          l = LEN_ONE;
    else if (c[7:5] == LEAD2_TAG) l = LEN_TWO;
    else if (c[7:4] == LEAD3_TAG) l = LEN_THR;
    else if (c[7:3] == LEAD4_TAG) l = LEN_FOUR;
    else                          l = LEN_BAD;
    return l;
  endfunction

endpackage

// ===== rtl/core/utf8d_fifo.sv =====
// Two-entry queue of packed words, used for runs and for results.
// Depends on utf8d_pkg for the queue depth.
`timescale 1ns / 1ps

module utf8d_fifo
  import utf8d_pkg::*;
#(
  parameter int Width = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [Width-1:0] slots [QDepth];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'(QDepth));
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

// ===== rtl/core/utf8d_front.sv =====
// Front end: accepts bytes, holds an open sequence and forms decode runs.
// Depends on utf8d_pkg for the run type and lead classification.
`timescale 1ns / 1ps

module utf8d_front
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] text_byte,
  input  logic             string_end,
  output job_push_t        job_out
);

  logic [ByteW-1:0] held_bytes [3];
  logic [1:0]       held_count;
  logic [LenW-1:0]  sequence_length;

  logic [LenW-1:0]  lead;
  logic [1:0]       base;
  logic             emit;
  logic             completes;

  assign lead = lead_len(text_byte);
  // Held bytes join the run only while a sequence is open.
  assign base = (sequence_length != LEN_BAD) ? held_count : 2'd0;
  assign completes = ({1'b0, held_count} + 3'd1 >= sequence_length) || (held_count == 2'd3);

  always_comb begin
    if (string_end)                       emit = 1'b1;
    else if (sequence_length == LEN_BAD)  emit = (lead == LEN_BAD) || (lead == LEN_ONE);
    else                                  emit = completes;
  end

  always_comb begin
    job_out.valid        = accept && emit;
    job_out.job.len      = {1'b0, base} + 3'd1;
    job_out.job.done     = string_end;
    job_out.job.bytes[0] = (base > 2'd0) ? held_bytes[0] : text_byte;
    job_out.job.bytes[1] = (base > 2'd1) ? held_bytes[1] : text_byte;
    job_out.job.bytes[2] = (base > 2'd2) ? held_bytes[2] : text_byte;
    job_out.job.bytes[3] = text_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      sequence_length <= LEN_BAD;
    end else if (accept) begin
      if (emit) begin
        held_count      <= 2'd0;
        sequence_length <= LEN_BAD;
      end else if (sequence_length == LEN_BAD) begin
        held_count      <= 2'd1;
        sequence_length <= lead;
      end else begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  // base stays below 3 whenever a byte is held
  always_ff @(posedge clk) begin
    if (accept && !emit) held_bytes[base] <= text_byte;
  end

endmodule

// ===== rtl/core/utf8d_back.sv =====
// Back end: walks one run per pop, one code point a cycle unless res_full.
// Depends on utf8d_pkg for the run and result types.
`timescale 1ns / 1ps

module utf8d_back
  import utf8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  job_t    job,
  input  logic    job_empty,
  output logic    job_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  logic [PosW-1:0]  pos;
  logic [ByteW-1:0] b0, b1, b2, b3;
  logic [LenW-1:0]  lead;
  logic [LenW-1:0]  ends;
  logic             fits;
  logic [LenW-1:0]  adv;
  logic [LenW-1:0]  next_pos;
  logic             last;
  logic [CpW-1:0]   cp;

  assign b0 = job.bytes[pos];
  assign b1 = job.bytes[pos + 2'd1];
  assign b2 = job.bytes[pos + 2'd2];
  assign b3 = job.bytes[pos + 2'd3];

  assign lead     = lead_len(b0);
  assign ends     = {1'b0, pos} + lead;
  assign fits     = (lead != LEN_BAD) && (ends <= job.len);
  assign adv      = fits ? lead : LEN_ONE;
  assign next_pos = {1'b0, pos} + adv;
  assign last     = (next_pos >= job.len);

  always_comb begin
    unique case (lead)
      LEN_TWO:  cp = {10'd0, b0[4:0], b1[5:0]};
      LEN_THR:  cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      LEN_FOUR: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:  cp = {13'd0, b0};
    endcase
  end

  assign res_push        = !job_empty && !res_full;
  assign job_pop         = res_push && last;
  assign res.code_point  = fits ? cp : REPLACEMENT;
  assign res.run_last    = last;
  assign res.string_done = last && job.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (res_push) begin
      pos <= last ? '0 : next_pos[PosW-1:0];
    end
  end

endmodule

// ===== rtl/core/utf8_code_point_decoder.sv =====
// Top level of the streaming UTF-8 to code point decoder.
// Depends on utf8d_pkg, utf8d_front, utf8d_back and utf8d_fifo.
`timescale 1ns / 1ps

// Takes bytes through a queue-like input (push/full) and delivers code points
// through a queue-like result port (empty/pop). ASCII bytes, bad leads
// (U+FFFD) and the last byte of a multi-byte sequence each yield a result;
// other bytes of a sequence are held. When string_end cuts a sequence short,
// the held bytes and the final byte are decoded again as one run, giving up
// to three results, with run_last on the last result of each byte and
// string_done on the last result of the string. The front end takes one byte
// per cycle while full is low; the back end emits one result per cycle while
// the result queue has room, so a byte that releases k results holds it
// until the last of them is pushed. The two-entry run queue lets one more run
// wait behind the one being worked on, and full rises while both entries are
// taken, which also happens once a held-low pop has filled the two-entry
// result queue. A byte's run is registered in the run queue, its results in the result queue.
module utf8_code_point_decoder
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] text_byte,
  input  logic             string_end,
  input  logic             pop,
  output logic             empty,
  output logic [CpW-1:0]   code_point,
  output logic             run_last,
  output logic             string_done
);

  // Front end: hold open sequences, form runs
  job_push_t front_job;
  logic      accept;

  assign accept = push && !full;

  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .string_end (string_end),
    .job_out    (front_job)
  );

  // Run queue decouples front and back; full back-pressures input
  job_t q_job;
  logic q_empty;
  logic q_pop;

  utf8d_fifo #(.Width($bits(job_t))) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_job.valid),
    .wdata (front_job.job),
    .pop   (q_pop),
    .rdata (q_job),
    .full  (full),
    .empty (q_empty)
  );

  // Back end: one result per cycle while the result queue has room
  result_t back_res;
  logic    res_push;
  logic    res_full;

  utf8d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Result queue doubles as the output register
  result_t out_res;

  utf8d_fifo #(.Width($bits(result_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .pop   (pop),
    .rdata (out_res),
    .full  (res_full),
    .empty (empty)
  );

  assign code_point  = out_res.code_point;
  assign run_last    = out_res.run_last;
  assign string_done = out_res.string_done;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for utf8_code_point_decoder: directed table, then random strings.
// Depends on utf8d_pkg (widths, REPLACEMENT, result_t) and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;
  import utf8d_pkg::*;

  // Max cycles with no transaction on either side before the run is abandoned.
  // Worst honest gap is the longest idle burst plus the path through both queues,
  // so this is generous.
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;     // drain time after the last expected result
  localparam int RANDOM_BYTES = 85;
  localparam int CALM_ROWS = 20;       // final rows run with no new idle bursts on either side

  // One row of stimulus. When typed is set, cp is the hand-written expected
  // code point (single result). Otherwise the row is checked against the
  // decoder model below.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             fin;
    logic             typed;
    logic [CpW-1:0]   cp;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  logic [ByteW-1:0] text_byte;
  logic             string_end;
  logic             pop;
  logic             empty;
  logic [CpW-1:0]   code_point;
  logic             run_last;
  logic             string_done;

  utf8_code_point_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .text_byte  (text_byte),
    .string_end (string_end),
    .pop        (pop),
    .empty      (empty),
    .code_point (code_point),
    .run_last   (run_last),
    .string_done(string_done)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  stim_row_t        stimulus[$];
  result_t          points_due[$];      // code points still owed by the decoder
  logic [ByteW-1:0] string_bytes[$];    // scratch while building one random string
  int               mismatches = 0;
  int               quiet_cycles = 0;
  bit               calm = 1'b0;        // set for the final stretch: no new idle bursts

  // Decoder model state: the open multi-byte sequence.
  logic [3:0][ByteW-1:0] pend_bytes = '0;
  int                    pend_cnt = 0;
  int                    open_len = 0;  // 0 means no sequence open

  // Length a lead byte announces; 0 for a continuation or 0xF8..0xFF.
  function automatic int lead_span(input logic [ByteW-1:0] b);
    int s;
    casez (b)
      8'b0???????: s = 1;
      8'b110?????: s = 2;
      8'b1110????: s = 3;
      8'b11110???: s = 4;
      default:     s = 0;
    endcase
    return s;
  endfunction

  // Combine span bytes starting at position at: lead payload bits, then six
  // bits from each continuation (continuation tags are not checked).
  function automatic logic [CpW-1:0] join_run(input logic [3:0][ByteW-1:0] run,
                                              input int at, input int span);
    logic [31:0] v;
    int          j;
    case (span)
      2:       v = run[at] & 8'h1F;
      3:       v = run[at] & 8'h0F;
      4:       v = run[at] & 8'h07;
      default: v = run[at];
    endcase
    for (j = 1; j < span; j++) v = (v << 6) | (run[at + j] & 8'h3F);
    return v[CpW-1:0];
  endfunction

  // Advance the model by one accepted byte. Results go to points_due unless
  // the row carries a typed expectation, in which case only the state moves.
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic fin,
                             input logic use_model);
    logic [3:0][ByteW-1:0] run;
    logic [CpW-1:0]        cps[4];
    int                    len, i, span, n, k;
    n = 0;
    run = '0;
    if (fin) begin
      // String end: held bytes plus this byte are re-decoded as one run.
      // A lead that does not fit gives U+FFFD and consumes just itself.
      len = 0;
      if (open_len != 0)
        for (i = 0; i < pend_cnt; i++) begin
          run[len] = pend_bytes[i];
          len++;
        end
      run[len] = b;
      len++;
      i = 0;
      while (i < len) begin
        span = lead_span(run[i]);
        if (span == 0 || i + span > len) begin
          cps[n] = REPLACEMENT;
          i++;
        end else begin
          cps[n] = join_run(run, i, span);
          i += span;
        end
        n++;
      end
      pend_cnt = 0;
      open_len = 0;
    end else if (open_len == 0) begin
      span = lead_span(b);
      if (span == 1) begin
        cps[n] = {{(CpW-ByteW){1'b0}}, b};
        n++;
      end else if (span == 0) begin
        cps[n] = REPLACEMENT;
        n++;
      end else begin
        pend_bytes[0] = b;
        pend_cnt = 1;
        open_len = span;
      end
    end else if (pend_cnt + 1 >= open_len) begin
      // This byte completes the open sequence.
      for (i = 0; i < pend_cnt; i++) run[i] = pend_bytes[i];
      run[pend_cnt] = b;
      cps[n] = join_run(run, 0, pend_cnt + 1);
      n++;
      pend_cnt = 0;
      open_len = 0;
    end else begin
      pend_bytes[pend_cnt] = b;
      pend_cnt++;
    end
    if (use_model)
      for (k = 0; k < n; k++)
        points_due.insert(points_due.size(),
                          result_t'{cps[k], k == n - 1, fin && (k == n - 1)});
  endtask

  task automatic add_row(input logic [ByteW-1:0] b, input logic fin,
                         input logic typed, input logic [CpW-1:0] cp);
    stimulus.insert(stimulus.size(), stim_row_t'{b, fin, typed, cp});
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    logic [ByteW-1:0] v;
    v = 8'($urandom);
    return {2'b10, v[5:0]};
  endfunction

  function automatic logic [ByteW-1:0] lead_byte(input int span);
    logic [ByteW-1:0] v;
    v = 8'($urandom);
    case (span)
      2:       v = {3'b110, v[4:0]};
      3:       v = {4'b1110, v[3:0]};
      4:       v = {5'b11110, v[2:0]};
      default: v = {1'b0, v[6:0]};
    endcase
    return v;
  endfunction

  // Lead of the given span followed by ncont continuation bytes.
  task automatic append_seq(input int span, input int ncont);
    string_bytes.insert(string_bytes.size(), lead_byte(span));
    repeat (ncont) string_bytes.insert(string_bytes.size(), cont_byte());
  endtask

  // Mostly well-formed strings with random payload bits; some raw noise
  // bytes and some strings cut off in the middle of a multi-byte sequence.
  task automatic queue_random_strings(input int want);
    int made, parts, kind, span, j;
    made = 0;
    while (made < want) begin
      string_bytes.delete();
      parts = $urandom_range(1, 6);
      repeat (parts) begin
        kind = $urandom_range(0, 9);
        if (kind <= 2)      append_seq(1, 0);
        else if (kind <= 4) append_seq(2, 1);
        else if (kind <= 6) append_seq(3, 2);
        else if (kind <= 8) append_seq(4, 3);
        else                string_bytes.insert(string_bytes.size(),
                                                8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
        span = $urandom_range(2, 4);
        append_seq(span, $urandom_range(0, span - 2));
      end
      for (j = 0; j < string_bytes.size(); j++)
        add_row(string_bytes[j], j == string_bytes.size() - 1, 1'b0, '0);
      made += string_bytes.size();
    end
  endtask

  // Byte side: walk the table, random idle bursts, predict on acceptance.
  initial begin
    int idx;
    rst = 1'b1;
    push = 1'b0;
    text_byte = '0;
    string_end = 1'b0;

    // Directed rows. Typed values are only used where no sequence is open.
    add_row(8'h00, 1'b0, 1'b1, 21'h000000);   // smallest ASCII
    add_row(8'h7F, 1'b0, 1'b1, 21'h00007F);   // largest ASCII
    add_row(8'h80, 1'b0, 1'b1, REPLACEMENT);  // continuation in lead position
    add_row(8'hFF, 1'b0, 1'b1, REPLACEMENT);  // invalid lead, all ones
    add_row(8'hF8, 1'b0, 1'b1, REPLACEMENT);  // invalid lead, just above 4-byte
    add_row(8'hC3, 1'b0, 1'b0, '0);           // two-byte sequence
    add_row(8'hA9, 1'b0, 1'b0, '0);
    add_row(8'hE2, 1'b0, 1'b0, '0);           // three-byte sequence
    add_row(8'h82, 1'b0, 1'b0, '0);
    add_row(8'hAC, 1'b0, 1'b0, '0);
    add_row(8'hF7, 1'b0, 1'b0, '0);           // four-byte, largest code point
    add_row(8'hBF, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b0, 1'b0, '0);
    add_row(8'hF0, 1'b0, 1'b0, '0);           // four-byte cut by string end:
    add_row(8'h9F, 1'b0, 1'b0, '0);           // three results from the last byte
    add_row(8'h41, 1'b1, 1'b0, '0);
    add_row(8'hE2, 1'b1, 1'b1, REPLACEMENT);  // multi-byte lead on the final byte
    add_row(8'hC0, 1'b0, 1'b0, '0);           // completed exactly at string end
    add_row(8'h80, 1'b1, 1'b0, '0);
    add_row(8'h41, 1'b1, 1'b1, 21'h000041);   // one-byte string
    queue_random_strings(RANDOM_BYTES);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < stimulus.size(); idx++) begin
      if (idx >= stimulus.size() - CALM_ROWS) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      push <= 1'b1;
      text_byte <= stimulus[idx].data;
      string_end <= stimulus[idx].fin;
      do @(posedge clk); while (full);
      // Transaction accepted at this edge.
      decode_byte(stimulus[idx].data, stimulus[idx].fin, !stimulus[idx].typed);
      if (stimulus[idx].typed)
        points_due.insert(points_due.size(),
                          result_t'{stimulus[idx].cp, 1'b1, stimulus[idx].fin});
      @(negedge clk);
    end
    push <= 1'b0;

    while (points_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Result side: pop with random stall bursts until the calm stretch.
  initial begin
    int hold;
    hold = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 9) - 1;
        pop <= 1'b0;
      end else begin
        pop <= !rst;
      end
    end
  end

  // Compare each popped result with the oldest outstanding expectation.
  result_t oldest;
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (points_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual cp=%h last=%b done=%b",
                 $time, code_point, run_last, string_done);
        mismatches++;
      end else begin
        oldest = points_due.pop_front();
        if (code_point !== oldest.code_point) begin
          $display("%0t: code_point expected %h actual %h",
                   $time, oldest.code_point, code_point);
          mismatches++;
        end
        if (run_last !== oldest.run_last) begin
          $display("%0t: run_last expected %b actual %b",
                   $time, oldest.run_last, run_last);
          mismatches++;
        end
        if (string_done !== oldest.string_done) begin
          $display("%0t: string_done expected %b actual %b",
                   $time, oldest.string_done, string_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: abort when neither side completes a transaction for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_fifo.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_code_point_decoder.sv
tb/testbench.sv
